@@ design/rlbc_pkg.sv @@
// Shared types and codes for the RGB LED blink/crossfade unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlbc_pkg;

  localparam int COLOR_W = 8;
  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;

  // command codes carried on in_func
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_SET_COLOR  = 3'd1;
  localparam logic [2:0] FUNC_FADE_TO    = 3'd2;
  localparam logic [2:0] FUNC_START_BLNK = 3'd3;
  localparam logic [2:0] FUNC_STOP_BLNK  = 3'd4;
  localparam logic [2:0] FUNC_STOP_FADE  = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_WAIT      = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] BLINK_INTERVAL_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] FADE_WAIT_RST      = 16'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } rlbc_state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               written;
    logic               fading;
    logic               blinking;
  } rlbc_result_t;

endpackage

`default_nettype wire

@@ design/rlbc_div.sv @@
// Bit-serial restoring divider: constant dividend over an 8-bit divisor,
// one quotient bit per cycle. Depends on rlbc_pkg.
`default_nettype none

module rlbc_div #(
  parameter int DIVIDEND = 1020
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start_i,
  input  wire logic [rlbc_pkg::COLOR_W-1:0]      divisor_i,
  output logic                                   done_o,
  output logic [$clog2(DIVIDEND+1)-1:0]          quot_o
);
  import rlbc_pkg::*;

  localparam int QW   = $clog2(DIVIDEND + 1);
  localparam int CNTW = $clog2(QW + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [QW-1:0]      dvd_r, dvd_nxt;
  logic [QW-1:0]      quot_r, quot_nxt;
  logic [COLOR_W-1:0] rem_r, rem_nxt;
  logic [COLOR_W-1:0] dsr_r, dsr_nxt;
  logic [COLOR_W:0]   trial;
  logic [COLOR_W:0]   diff;
  logic               ge;

  always_comb begin
    trial    = {rem_r, dvd_r[QW-1]};
    ge       = (trial >= {1'b0, dsr_r});
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(QW);
      dvd_nxt  = QW'(DIVIDEND);
      quot_nxt = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so 8 bits hold it
      rem_nxt  = ge ? diff[COLOR_W-1:0] : trial[COLOR_W-1:0];
      quot_nxt = {quot_r[QW-2:0], ge};
      dvd_nxt  = {dvd_r[QW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

`default_nettype wire

@@ design/rlbc_out_buf.sv @@
// Two-entry result buffer: output register plus one skid entry.
// Depends on rlbc_pkg for the result struct.
`default_nettype none

module rlbc_out_buf (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push_i,
  input  wire rlbc_pkg::rlbc_result_t push_data_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output rlbc_pkg::rlbc_result_t      out_data_o
);
  import rlbc_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         spare_valid_r, spare_valid_nxt;
  rlbc_result_t out_r, out_nxt;
  rlbc_result_t spare_r, spare_nxt;
  logic         out_free;

  always_comb begin
    out_free        = !out_valid_r || out_ready_i;
    out_valid_nxt   = out_valid_r;
    spare_valid_nxt = spare_valid_r;
    out_nxt         = out_r;
    spare_nxt       = spare_r;
    if (out_free) begin
      if (spare_valid_r) begin
        out_nxt         = spare_r;
        out_valid_nxt   = 1'b1;
        spare_nxt       = push_data_i;
        spare_valid_nxt = push_i;
      end else begin
        out_nxt       = push_data_i;
        out_valid_nxt = push_i;
      end
    end else if (push_i) begin
      spare_nxt       = push_data_i;
      spare_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
    out_r   <= out_nxt;
    spare_r <= spare_nxt;
  end

  assign full_o      = spare_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

endmodule

`default_nettype wire

@@ design/rgb_led_blink_crossfade_unit.sv @@
// Top level of the RGB LED blink/crossfade unit.
// Depends on rlbc_pkg, rlbc_div and rlbc_out_buf.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick or command per
//   transaction; every transaction yields exactly one result transaction on
//   out_valid/out_ready with the driven duties and the fade/blink flags.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   blink_interval (index 0) and fade_wait (index 1); it is always ready
//   and is meant to be used while the block is idle.
//   Each result is registered in the output buffer before it is presented.
//   Ticks and all commands but fade-to are accepted back to back while the
//   output buffer has room. A fade-to starts three bit-serial divider lanes
//   (one per channel) that produce one quotient bit per cycle, so the input
//   stays closed until the lanes are done and the step magnitudes are loaded.
//   The per-channel step test uses running modulo counters, so ticks need
//   no divider.
//   Reset (rst_n low, synchronous) clears colors, steps, timers and flags
//   and restores blink_interval=500 and fade_wait=1.
//   A stalled receiver is absorbed by a two-entry output buffer; input is
//   refused once both entries hold results, and while the divider lanes run.
`default_nettype none

module rgb_led_blink_crossfade_unit #(
  parameter int FADE_STEPS = 1020,
  parameter int TIMER_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [2:0]                        in_func,
  input  wire logic [rlbc_pkg::COLOR_W-1:0]      in_red_value,
  input  wire logic [rlbc_pkg::COLOR_W-1:0]      in_green_value,
  input  wire logic [rlbc_pkg::COLOR_W-1:0]      in_blue_value,
  input  wire logic                              in_remember,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rlbc_pkg::COLOR_W-1:0]           out_drive_red,
  output logic [rlbc_pkg::COLOR_W-1:0]           out_drive_green,
  output logic [rlbc_pkg::COLOR_W-1:0]           out_drive_blue,
  output logic                                   out_drive_written,
  output logic                                   out_fading,
  output logic                                   out_blinking,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rlbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rlbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rlbc_pkg::*;

  localparam int QW = $clog2(FADE_STEPS + 1);
  localparam int PW = QW;
  localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  rlbc_state_t            state_r, state_nxt;
  logic [CFG_DATA_W-1:0]  blink_int_r, blink_int_nxt;
  logic [CFG_DATA_W-1:0]  fade_wait_r, fade_wait_nxt;
  logic [COLOR_W-1:0]     rem_col_r [3];
  logic [COLOR_W-1:0]     rem_col_nxt [3];
  logic [COLOR_W-1:0]     drv_col_r [3];
  logic [COLOR_W-1:0]     drv_col_nxt [3];
  logic [QW-1:0]          step_mag_r [3];
  logic [QW-1:0]          step_mag_nxt [3];
  logic [QW-1:0]          mod_cnt_r [3];
  logic [QW-1:0]          mod_cnt_nxt [3];
  logic [2:0]             step_down_r, step_down_nxt;
  logic [2:0]             step_zero_r, step_zero_nxt;
  logic [PW-1:0]          fade_pos_r, fade_pos_nxt;
  logic                   fade_act_r, fade_act_nxt;
  logic                   blink_act_r, blink_act_nxt;
  logic                   blink_on_r, blink_on_nxt;
  logic [TIMER_BITS-1:0]  blink_el_r, blink_el_nxt;
  logic [TIMER_BITS-1:0]  fade_el_r, fade_el_nxt;

  logic                   in_fire;
  logic                   buf_full;
  logic                   res_push;
  rlbc_result_t           res;
  rlbc_result_t           out_data;
  logic                   written;
  logic                   div_start;
  logic [2:0]             div_done;
  logic [QW-1:0]          div_quot [3];
  logic [COLOR_W-1:0]     div_dsr [3];
  logic [COLOR_W-1:0]     tgt [3];
  logic signed [COLOR_W:0] gap [3];
  logic [TIMER_BITS-1:0]  be_inc;
  logic [TIMER_BITS-1:0]  fe_inc;
  logic                   blink_due;
  logic                   fade_due;
  logic                   move;

  assign in_ready  = (state_r == ST_IDLE) && !buf_full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign tgt[0] = in_red_value;
  assign tgt[1] = in_green_value;
  assign tgt[2] = in_blue_value;

  // gap and its magnitude per channel, for the fade-to command
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gap[k]     = $signed({1'b0, tgt[k]}) - $signed({1'b0, rem_col_r[k]});
      div_dsr[k] = gap[k][COLOR_W] ? COLOR_W'(-gap[k]) : gap[k][COLOR_W-1:0];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    rlbc_div #(
      .DIVIDEND (FADE_STEPS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .start_i   (div_start),
      .divisor_i (div_dsr[g]),
      .done_o    (div_done[g]),
      .quot_o    (div_quot[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    blink_int_nxt = blink_int_r;
    fade_wait_nxt = fade_wait_r;
    rem_col_nxt   = rem_col_r;
    drv_col_nxt   = drv_col_r;
    step_mag_nxt  = step_mag_r;
    mod_cnt_nxt   = mod_cnt_r;
    step_down_nxt = step_down_r;
    step_zero_nxt = step_zero_r;
    fade_pos_nxt  = fade_pos_r;
    fade_act_nxt  = fade_act_r;
    blink_act_nxt = blink_act_r;
    blink_on_nxt  = blink_on_r;
    blink_el_nxt  = blink_el_r;
    fade_el_nxt   = fade_el_r;
    written       = 1'b0;
    res_push      = 1'b0;
    div_start     = 1'b0;
    move          = 1'b0;

    be_inc    = (blink_el_r == TMAX) ? blink_el_r : blink_el_r + 1'b1;
    fe_inc    = (fade_el_r == TMAX) ? fade_el_r : fade_el_r + 1'b1;
    blink_due = blink_act_r && (CW'(be_inc) >= CW'(blink_int_r));
    fade_due  = fade_act_r && (CW'(fe_inc) >= CW'(fade_wait_r));

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLINK_INTERVAL: blink_int_nxt = cfg_data;
        CFG_FADE_WAIT:      fade_wait_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_push = 1'b1;
          unique case (in_func)
            FUNC_TICK: begin
              blink_el_nxt = be_inc;
              fade_el_nxt  = fe_inc;
              if (blink_due) begin
                for (int k = 0; k < 3; k++)
                  drv_col_nxt[k] = blink_on_r ? rem_col_r[k] : '0;
                written      = 1'b1;
                blink_el_nxt = '0;
                blink_on_nxt = !blink_on_r;
              end
              if (fade_due) begin
                if (fade_pos_r >= PW'(FADE_STEPS)) begin
                  fade_act_nxt = 1'b0;
                end else begin
                  fade_el_nxt = '0;
                  for (int k = 0; k < 3; k++) begin
                    // mod_cnt tracks fade_pos modulo the step magnitude
                    move = !step_zero_r[k] && (mod_cnt_r[k] == '0);
                    if (move && !step_down_r[k] && rem_col_r[k] != COLOR_MAX)
                      rem_col_nxt[k] = rem_col_r[k] + 1'b1;
                    else if (move && step_down_r[k] && rem_col_r[k] != '0)
                      rem_col_nxt[k] = rem_col_r[k] - 1'b1;
                    mod_cnt_nxt[k] = (QW'(mod_cnt_r[k] + 1'b1) == step_mag_r[k]) ?
                                     '0 : mod_cnt_r[k] + 1'b1;
                    drv_col_nxt[k] = rem_col_nxt[k];
                  end
                  fade_pos_nxt = fade_pos_r + 1'b1;
                  written      = 1'b1;
                end
              end
            end
            FUNC_SET_COLOR: begin
              for (int k = 0; k < 3; k++) begin
                drv_col_nxt[k] = tgt[k];
                if (in_remember)
                  rem_col_nxt[k] = tgt[k];
              end
              written = 1'b1;
            end
            FUNC_FADE_TO: begin
              for (int k = 0; k < 3; k++) begin
                step_down_nxt[k] = gap[k][COLOR_W];
                step_zero_nxt[k] = (gap[k] == '0);
                mod_cnt_nxt[k]   = '0;
              end
              fade_pos_nxt = '0;
              fade_act_nxt = 1'b1;
              div_start    = 1'b1;
              state_nxt    = ST_DIV;
            end
            FUNC_START_BLNK: begin
              blink_act_nxt = 1'b1;
              blink_on_nxt  = 1'b0;
            end
            FUNC_STOP_BLNK: blink_act_nxt = 1'b0;
            FUNC_STOP_FADE: fade_act_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done[0]) begin
          for (int k = 0; k < 3; k++)
            step_mag_nxt[k] = div_quot[k];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    res.red      = drv_col_nxt[0];
    res.green    = drv_col_nxt[1];
    res.blue     = drv_col_nxt[2];
    res.written  = written;
    res.fading   = fade_act_nxt;
    res.blinking = blink_act_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blink_int_r <= BLINK_INTERVAL_RST;
      fade_wait_r <= FADE_WAIT_RST;
      for (int k = 0; k < 3; k++) begin
        rem_col_r[k]  <= '0;
        drv_col_r[k]  <= '0;
        step_mag_r[k] <= '0;
        mod_cnt_r[k]  <= '0;
      end
      step_down_r <= '0;
      step_zero_r <= '1;
      fade_pos_r  <= '0;
      fade_act_r  <= 1'b0;
      blink_act_r <= 1'b0;
      blink_on_r  <= 1'b0;
      blink_el_r  <= '0;
      fade_el_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      blink_int_r <= blink_int_nxt;
      fade_wait_r <= fade_wait_nxt;
      rem_col_r   <= rem_col_nxt;
      drv_col_r   <= drv_col_nxt;
      step_mag_r  <= step_mag_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      step_down_r <= step_down_nxt;
      step_zero_r <= step_zero_nxt;
      fade_pos_r  <= fade_pos_nxt;
      fade_act_r  <= fade_act_nxt;
      blink_act_r <= blink_act_nxt;
      blink_on_r  <= blink_on_nxt;
      blink_el_r  <= blink_el_nxt;
      fade_el_r   <= fade_el_nxt;
    end
  end

  rlbc_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  assign out_drive_red     = out_data.red;
  assign out_drive_green   = out_data.green;
  assign out_drive_blue    = out_data.blue;
  assign out_drive_written = out_data.written;
  assign out_fading        = out_data.fading;
  assign out_blinking      = out_data.blinking;

  // a fade-to transaction always hands off to the divider lanes
  a_fade_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func == FUNC_FADE_TO) |=> state_r == ST_DIV)
    else $error("fade-to did not start the step division");

  // no result may be produced and no input accepted while steps are being computed
  a_no_push_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !res_push && !in_ready)
    else $error("result or acceptance during step division");

  // fade position never runs past the end of the fade
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fade_act_r |-> fade_pos_r <= PW'(FADE_STEPS))
    else $error("fade position overran");

  // the divider lanes finish together
  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (div_done == 3'b111) && $past(state_r == ST_DIV))
    else $error("divider lanes out of step");

endmodule

`default_nettype wire

@@ tb/sv/rgb_led_blink_crossfade_unit_test.sv @@
// Self-checking testbench for rgb_led_blink_crossfade_unit: blink, crossfade and
// timer behavior checked against an in-bench duty predictor, transaction by transaction.
// Depends on rlbc_pkg and the RTL of the unit only.
`default_nettype none

module rgb_led_blink_crossfade_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rlbc_pkg::*;

  localparam int          FADE_STEPS     = 1020;
  localparam int unsigned TIMER_MAX      = 65535;
  localparam logic [2:0]  FUNC_SPARE_6   = 3'd6;
  localparam logic [2:0]  FUNC_SPARE_7   = 3'd7;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 24;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]         func;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               remember;
  } led_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_func = FUNC_TICK;
  logic [COLOR_W-1:0]    in_red_value = '0;
  logic [COLOR_W-1:0]    in_green_value = '0;
  logic [COLOR_W-1:0]    in_blue_value = '0;
  logic                  in_remember = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COLOR_W-1:0]    out_drive_red;
  logic [COLOR_W-1:0]    out_drive_green;
  logic [COLOR_W-1:0]    out_drive_blue;
  logic                  out_drive_written;
  logic                  out_fading;
  logic                  out_blinking;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLINK_INTERVAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rgb_led_blink_crossfade_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_red_value      (in_red_value),
    .in_green_value    (in_green_value),
    .in_blue_value     (in_blue_value),
    .in_remember       (in_remember),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_red     (out_drive_red),
    .out_drive_green   (out_drive_green),
    .out_drive_blue    (out_drive_blue),
    .out_drive_written (out_drive_written),
    .out_fading        (out_fading),
    .out_blinking      (out_blinking),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [COLOR_W-1:0]    mem_rgb [3];
  logic [COLOR_W-1:0]    drv_rgb [3];
  int                    step_of [3];
  int unsigned           fade_pos;
  bit                    fade_on;
  bit                    blink_on;
  bit                    blink_lit;
  int unsigned           blink_ms;
  int unsigned           fade_ms;
  logic [CFG_DATA_W-1:0] blink_period;
  logic [CFG_DATA_W-1:0] fade_period;

  // queues and bookkeeping
  led_cmd_t     cmd_pending_q[$];
  rlbc_result_t duty_expect_q[$];
  led_cmd_t     cmd_on_bus;
  rlbc_result_t duty_got;
  rlbc_result_t duty_want;
  int           items_issued = 0;
  int           items_accepted = 0;
  int           results_checked = 0;
  int           mismatches = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           seg_left = 0;
  int           seg_mode = 0;
  int           hold_left = 0;
  int           holds_asked = 0;
  int           holds_served = 0;
  int           idle_cycles = 0;
  bit           steady = 1'b0;

  function automatic void clear_duty_state();
    for (int k = 0; k < 3; k++) begin
      mem_rgb[k] = '0;
      drv_rgb[k] = '0;
      step_of[k] = 0;
    end
    fade_pos     = 0;
    fade_on      = 1'b0;
    blink_on     = 1'b0;
    blink_lit    = 1'b0;
    blink_ms     = 0;
    fade_ms      = 0;
    blink_period = BLINK_INTERVAL_RST;
    fade_period  = FADE_WAIT_RST;
  endfunction

  // Applies one command to the predictor and returns the duties it should report.
  function automatic rlbc_result_t predict_duty(input led_cmd_t c);
    rlbc_result_t       res;
    logic               wrote;
    logic [COLOR_W-1:0] tgt [3];
    int                 gap;
    int                 v;
    int unsigned        mag;
    wrote  = 1'b0;
    tgt[0] = c.red;
    tgt[1] = c.green;
    tgt[2] = c.blue;
    case (c.func)
      FUNC_TICK: begin
        if (blink_ms < TIMER_MAX) blink_ms++;
        if (fade_ms < TIMER_MAX) fade_ms++;
        if (blink_on && blink_ms >= blink_period) begin
          for (int k = 0; k < 3; k++) drv_rgb[k] = blink_lit ? mem_rgb[k] : '0;
          wrote     = 1'b1;
          blink_ms  = 0;
          blink_lit = !blink_lit;
        end
        if (fade_on && fade_ms >= fade_period) begin
          if (fade_pos >= FADE_STEPS) begin
            fade_on = 1'b0;
          end else begin
            fade_ms = 0;
            for (int k = 0; k < 3; k++) begin
              v = mem_rgb[k];
              if (step_of[k] != 0) begin
                mag = (step_of[k] < 0) ? -step_of[k] : step_of[k];
                if (fade_pos % mag == 0) v += (step_of[k] > 0) ? 1 : -1;
              end
              if (v > 255) v = 255;
              if (v < 0) v = 0;
              mem_rgb[k] = v[COLOR_W-1:0];
              drv_rgb[k] = mem_rgb[k];
            end
            fade_pos++;
            wrote = 1'b1;
          end
        end
      end
      FUNC_SET_COLOR: begin
        for (int k = 0; k < 3; k++) begin
          if (c.remember) mem_rgb[k] = tgt[k];
          drv_rgb[k] = tgt[k];
        end
        wrote = 1'b1;
      end
      FUNC_FADE_TO: begin
        fade_pos = 0;
        for (int k = 0; k < 3; k++) begin
          gap = int'(tgt[k]) - int'(mem_rgb[k]);
          step_of[k] = (gap == 0) ? 0 : FADE_STEPS / gap;
        end
        fade_on = 1'b1;
      end
      FUNC_START_BLNK: begin
        blink_on  = 1'b1;
        blink_lit = 1'b0;
      end
      FUNC_STOP_BLNK: blink_on = 1'b0;
      FUNC_STOP_FADE: fade_on = 1'b0;
      default: ;
    endcase
    res.red      = drv_rgb[0];
    res.green    = drv_rgb[1];
    res.blue     = drv_rgb[2];
    res.written  = wrote;
    res.fading   = fade_on;
    res.blinking = blink_on;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        duty_expect_q.push_back(predict_duty(cmd_on_bus));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && !steady) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_pending_q.size() > 0) begin
          cmd_on_bus = cmd_pending_q.pop_front();
          in_func        <= cmd_on_bus.func;
          in_red_value   <= cmd_on_bus.red;
          in_green_value <= cmd_on_bus.green;
          in_blue_value  <= cmd_on_bus.blue;
          in_remember    <= cmd_on_bus.remember;
          in_valid       <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        duty_got = '{out_drive_red, out_drive_green, out_drive_blue,
                     out_drive_written, out_fading, out_blinking};
        if (duty_expect_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          duty_want = duty_expect_q.pop_front();
          results_checked++;
          if (duty_got.red != duty_want.red)
            report_mismatch("drive_red", duty_got.red, duty_want.red);
          if (duty_got.green != duty_want.green)
            report_mismatch("drive_green", duty_got.green, duty_want.green);
          if (duty_got.blue != duty_want.blue)
            report_mismatch("drive_blue", duty_got.blue, duty_want.blue);
          if (duty_got.written != duty_want.written)
            report_mismatch("drive_written", duty_got.written, duty_want.written);
          if (duty_got.fading != duty_want.fading)
            report_mismatch("fading", duty_got.fading, duty_want.fading);
          if (duty_got.blinking != duty_want.blinking)
            report_mismatch("blinking", duty_got.blinking, duty_want.blinking);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 64);
          seg_mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (seg_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= !out_ready;
        endcase
      end
    end
  end

  // watchdog: cycles in a row with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [2:0] f, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b, input logic rem);
    led_cmd_t c;
    c.func     = f;
    c.red      = r;
    c.green    = g;
    c.blue     = b;
    c.remember = rem;
    cmd_pending_q.push_back(c);
    items_issued++;
  endtask

  function automatic logic [7:0] pick_duty();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_random_cmd();
    int         roll;
    logic [2:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 62)      f = FUNC_TICK;
    else if (roll < 72) f = FUNC_SET_COLOR;
    else if (roll < 80) f = FUNC_FADE_TO;
    else if (roll < 87) f = FUNC_START_BLNK;
    else if (roll < 93) f = FUNC_STOP_BLNK;
    else if (roll < 97) f = FUNC_STOP_FADE;
    else                f = ($urandom_range(0, 1) == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    push_cmd(f, pick_duty(), pick_duty(), pick_duty(), 1'($urandom_range(0, 1)));
  endtask

  // sender pauses until every expected result is in, then lets the block go quiet
  task automatic wait_drained();
    while (items_accepted != items_issued || results_checked != items_accepted)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timer_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BLINK_INTERVAL) blink_period = val;
    else fade_period = val;
  endtask

  initial begin : stimulus
    int roll;
    clear_duty_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset timers, unused codes, remember on/off, extremes
    push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_SET_COLOR, 8'd255, 8'd255, 8'd255, 1'b1);
    push_cmd(FUNC_SET_COLOR, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_SPARE_6, 8'd255, 8'd255, 8'd255, 1'b1);
    push_cmd(FUNC_SPARE_7, 8'd170, 8'd85, 8'd15, 1'b0);
    push_cmd(FUNC_FADE_TO, 8'd0, 8'd128, 8'd255, 1'b0);
    repeat (3) push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_STOP_FADE, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();
    write_timer_reg(CFG_BLINK_INTERVAL, 16'd0);
    push_cmd(FUNC_START_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
    repeat (2) push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    // blink and fade writing on the same tick: fade values win
    push_cmd(FUNC_FADE_TO, 8'd255, 8'd0, 8'd254, 1'b1);
    repeat (2) push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_START_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_SET_COLOR, 8'd17, 8'd34, 8'd51, 1'b1);
    push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_STOP_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_STOP_FADE, 8'd0, 8'd0, 8'd0, 1'b0);
    // zero gaps everywhere: steps of zero
    push_cmd(FUNC_SET_COLOR, 8'd17, 8'd34, 8'd51, 1'b1);
    push_cmd(FUNC_FADE_TO, 8'd17, 8'd34, 8'd51, 1'b0);
    push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();

    // largest intervals: a short run of ticks brings nothing due
    write_timer_reg(CFG_BLINK_INTERVAL, 16'hFFFF);
    write_timer_reg(CFG_FADE_WAIT, 16'hFFFF);
    push_cmd(FUNC_STOP_FADE, 8'd0, 8'd0, 8'd0, 1'b0);
    steady = 1'b1;
    repeat (8) push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_SET_COLOR, 8'd200, 8'd100, 8'd50, 1'b1);
    push_cmd(FUNC_START_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(FUNC_FADE_TO, 8'd0, 8'd255, 8'd50, 1'b0);
    repeat (3) push_cmd(FUNC_TICK, 8'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();
    steady = 1'b0;

    // a long fade run, with blink and colour commands mixed in
    write_timer_reg(CFG_BLINK_INTERVAL, 16'd7);
    write_timer_reg(CFG_FADE_WAIT, 16'd0);
    push_cmd(FUNC_SET_COLOR, 8'd255, 8'd0, pick_duty(), 1'b1);
    push_cmd(FUNC_FADE_TO, 8'd0, 8'd255, pick_duty(), 1'b0);
    repeat (300) begin
      roll = $urandom_range(0, 99);
      if (roll < 94)
        push_cmd(FUNC_TICK, pick_duty(), pick_duty(), pick_duty(), 1'($urandom_range(0, 1)));
      else if (roll < 96)
        push_cmd(FUNC_SET_COLOR, pick_duty(), pick_duty(), pick_duty(),
                 1'($urandom_range(0, 1)));
      else if (roll < 98)
        push_cmd(FUNC_START_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
      else
        push_cmd(FUNC_STOP_BLNK, 8'd0, 8'd0, 8'd0, 1'b0);
    end
    wait_drained();

    // random phases under different timer settings
    for (int ph = 0; ph < 4; ph++) begin
      write_timer_reg(CFG_BLINK_INTERVAL, 16'($urandom_range(0, 8)));
      write_timer_reg(CFG_FADE_WAIT, 16'($urandom_range(0, 3)));
      // long receiver hold-off while the sender keeps offering transactions
      if (ph == 1) holds_asked++;
      repeat (90) push_random_cmd();
      wait_drained();
    end

    if (mismatches == 0 && duty_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/rlbc_pkg.sv
design/rlbc_div.sv
design/rlbc_out_buf.sv
design/rgb_led_blink_crossfade_unit.sv
tb/sv/rgb_led_blink_crossfade_unit_test.sv
